// File: hdl/y2yc_pkg.sv
package y2yc_pkg;

  localparam int PIX_W    = 16;
  localparam int COEF_W   = 16;
  localparam int LUMA_W   = 14;
  localparam int CHROMA_W = 13;
  localparam int PROD_W   = CHROMA_W + COEF_W;
  localparam int EXP_W    = 29;
  localparam int HI_SHIFT = 16;
  localparam int MIX_SHIFT = 14;

  localparam logic [14:0] LUMA_GAIN   = 15'd19152;
  localparam logic [14:0] CHROMA_GAIN = 15'd18752;
  localparam logic signed [13:0] LUMA_OFFSET   = 14'sd299;
  localparam logic signed [13:0] CHROMA_OFFSET = 14'sd2340;

  localparam logic signed [COEF_W-1:0] RST_LUMA_FROM_CB = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_LUMA_FROM_CR = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_CB_FROM_CB   = 16'sd16384;
  localparam logic signed [COEF_W-1:0] RST_CB_FROM_CR   = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_CR_FROM_CB   = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_CR_FROM_CR   = 16'sd16384;

  typedef logic signed [LUMA_W-1:0]   luma_t;
  typedef logic signed [CHROMA_W-1:0] chroma_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef enum logic [2:0] {
    REG_LUMA_FROM_CB = 3'd0,
    REG_LUMA_FROM_CR = 3'd1,
    REG_CB_FROM_CB   = 3'd2,
    REG_CB_FROM_CR   = 3'd3,
    REG_CR_FROM_CB   = 3'd4,
    REG_CR_FROM_CR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic issue;
    logic sel_new;
    logic odd;
    logic le;
    logic last;
    logic cap_load;
    logic hold_from_in;
    logic hold_from_cap;
  } ctl_cmd_t;

  typedef struct packed {
    logic adv;
  } dp_stat_t;

  function automatic luma_t expand_luma(input logic [7:0] y);
    logic [EXP_W-1:0] p;
    p = {15'd0, y, 6'd0} * {14'd0, LUMA_GAIN};
    return luma_t'($signed({1'b0, p[EXP_W-1:HI_SHIFT]}) - LUMA_OFFSET);
  endfunction

  function automatic chroma_t expand_chroma(input logic [7:0] c);
    logic [EXP_W-1:0] p;
    logic signed [13:0] d;
    p = {15'd0, c, 6'd0} * {14'd0, CHROMA_GAIN};
    d = $signed({1'b0, p[EXP_W-1:HI_SHIFT]}) - CHROMA_OFFSET;
    return d[CHROMA_W-1:0];
  endfunction

  function automatic chroma_t avg_chroma(input chroma_t a, input chroma_t b);
    logic signed [CHROMA_W:0] s;
    s = {a[CHROMA_W-1], a} + {b[CHROMA_W-1], b} + (CHROMA_W+1)'(1);
    return s[CHROMA_W:1];
  endfunction

endpackage

// File: hdl/y2yc_ctrl.sv
module y2yc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_line_end,
  output logic                in_ready,
  input  y2yc_pkg::dp_stat_t  stat,
  output y2yc_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HEVEN = 5'b00010,
    ST_HODD  = 5'b00100,
    ST_NEVEN = 5'b01000,
    ST_NODD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   held_valid_r, held_valid_nxt;
  logic   cap_le_r, cap_le_nxt;
  logic   last_issue;
  logic   take;

  assign last_issue = ((state_r == ST_HODD) && !cap_le_r) || (state_r == ST_NODD);
  assign in_ready   = (state_r == ST_IDLE) || (last_issue && stat.adv);
  assign take       = in_valid && in_ready;

  always_comb begin
    cmd.issue         = stat.adv && (state_r != ST_IDLE);
    cmd.sel_new       = (state_r == ST_NEVEN) || (state_r == ST_NODD);
    cmd.odd           = (state_r == ST_HODD) || (state_r == ST_NODD);
    cmd.le            = (state_r == ST_NODD);
    cmd.last          = last_issue;
    cmd.cap_load      = take;
    cmd.hold_from_in  = take && !held_valid_r && !in_line_end;
    cmd.hold_from_cap = stat.adv && (state_r == ST_HODD) && !cap_le_r;
  end

  always_comb begin
    state_nxt      = state_r;
    held_valid_nxt = take ? !in_line_end : held_valid_r;
    cap_le_nxt     = take ? in_line_end : cap_le_r;
    unique case (state_r)
      ST_IDLE:  state_nxt = ST_IDLE;
      ST_HEVEN: if (stat.adv) state_nxt = ST_HODD;
      ST_HODD:  if (stat.adv) state_nxt = cap_le_r ? ST_NEVEN : ST_IDLE;
      ST_NEVEN: if (stat.adv) state_nxt = ST_NODD;
      ST_NODD:  if (stat.adv) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (take) begin
      if (held_valid_r) begin
        state_nxt = ST_HEVEN;
      end else begin
        state_nxt = in_line_end ? ST_NEVEN : ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_valid_r <= 1'b0;
      cap_le_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_valid_r <= held_valid_nxt;
      cap_le_r     <= cap_le_nxt;
    end
  end

  a_take_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (state_r == ST_IDLE || state_r == ST_HODD || state_r == ST_NODD))
    else $error("beat accepted while pixels still pending");

  a_hold_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.hold_from_in && cmd.hold_from_cap))
    else $error("held pair loaded from two sources");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NODD && stat.adv && !take) |=> (state_r == ST_IDLE && !held_valid_r))
    else $error("line flush did not return to idle");

  a_hold_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HODD && stat.adv && !cap_le_r && !take) |=> held_valid_r)
    else $error("held pair lost after odd pixel");

endmodule

// File: hdl/y2yc_dpath.sv
module y2yc_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          in_luma_even,
  input  logic [7:0]          in_chroma_b,
  input  logic [7:0]          in_luma_odd,
  input  logic [7:0]          in_chroma_r,
  input  y2yc_pkg::ctl_cmd_t  cmd,
  output y2yc_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_pix_luma,
  output logic signed [15:0]  out_pix_cb,
  output logic signed [15:0]  out_pix_cr,
  output logic                out_pixel_line_end,
  output logic                out_run_last
);

  localparam int PW = y2yc_pkg::PIX_W;
  localparam int LW = y2yc_pkg::LUMA_W;
  localparam int QW = y2yc_pkg::PROD_W;
  localparam int HS = y2yc_pkg::HI_SHIFT;
  localparam int MS = y2yc_pkg::MIX_SHIFT;

  // coefficients
  y2yc_pkg::coef_t k_lcb_r, k_lcr_r, k_bb_r, k_br_r, k_rb_r, k_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_lcb_r <= y2yc_pkg::RST_LUMA_FROM_CB;
      k_lcr_r <= y2yc_pkg::RST_LUMA_FROM_CR;
      k_bb_r  <= y2yc_pkg::RST_CB_FROM_CB;
      k_br_r  <= y2yc_pkg::RST_CB_FROM_CR;
      k_rb_r  <= y2yc_pkg::RST_CR_FROM_CB;
      k_rr_r  <= y2yc_pkg::RST_CR_FROM_CR;
    end else if (cfg_we) begin
      unique case (y2yc_pkg::reg_idx_t'(cfg_index))
        y2yc_pkg::REG_LUMA_FROM_CB: k_lcb_r <= $signed(cfg_data);
        y2yc_pkg::REG_LUMA_FROM_CR: k_lcr_r <= $signed(cfg_data);
        y2yc_pkg::REG_CB_FROM_CB:   k_bb_r  <= $signed(cfg_data);
        y2yc_pkg::REG_CB_FROM_CR:   k_br_r  <= $signed(cfg_data);
        y2yc_pkg::REG_CR_FROM_CB:   k_rb_r  <= $signed(cfg_data);
        y2yc_pkg::REG_CR_FROM_CR:   k_rr_r  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // capture and held macropixels
  logic [7:0] cap_ye_r, cap_cb_r, cap_yo_r, cap_cr_r;
  logic [7:0] hld_ye_r, hld_cb_r, hld_yo_r, hld_cr_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_load) begin
      cap_ye_r <= in_luma_even;
      cap_cb_r <= in_chroma_b;
      cap_yo_r <= in_luma_odd;
      cap_cr_r <= in_chroma_r;
    end
    if (cmd.hold_from_in) begin
      hld_ye_r <= in_luma_even;
      hld_cb_r <= in_chroma_b;
      hld_yo_r <= in_luma_odd;
      hld_cr_r <= in_chroma_r;
    end else if (cmd.hold_from_cap) begin
      hld_ye_r <= cap_ye_r;
      hld_cb_r <= cap_cb_r;
      hld_yo_r <= cap_yo_r;
      hld_cr_r <= cap_cr_r;
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign stat.adv = adv;

  // stage 1: expand
  logic [7:0] src_ye, src_yo, src_cb, src_cr, src_y;
  assign src_ye = cmd.sel_new ? cap_ye_r : hld_ye_r;
  assign src_yo = cmd.sel_new ? cap_yo_r : hld_yo_r;
  assign src_cb = cmd.sel_new ? cap_cb_r : hld_cb_r;
  assign src_cr = cmd.sel_new ? cap_cr_r : hld_cr_r;
  assign src_y  = cmd.odd ? src_yo : src_ye;

  logic v1_r, v2_r, v3_r;
  y2yc_pkg::luma_t   s1_y_r;
  y2yc_pkg::chroma_t s1_cb0_r, s1_cr0_r, s1_cb1_r, s1_cr1_r;
  logic              s1_odd_r, s1_le_r, s1_last_r;

  // stage 2: upsample
  y2yc_pkg::luma_t   s2_y_r;
  y2yc_pkg::chroma_t s2_cb_r, s2_cr_r;
  logic              s2_le_r, s2_last_r;

  // stage 3: matrix products
  y2yc_pkg::luma_t   s3_y_r;
  y2yc_pkg::prod_t   s3_lcb_r, s3_lcr_r, s3_bb_r, s3_br_r, s3_rb_r, s3_rr_r;
  logic              s3_le_r, s3_last_r;

  // stage 4: sums
  logic signed [PW-1:0] luma_sum;
  logic signed [QW:0]   cb_mix, cr_mix;
  logic signed [PW-1:0] pix_luma_r, pix_cb_r, pix_cr_r;
  logic                 pix_le_r, pix_last_r;

  assign luma_sum = {{(PW-LW){s3_y_r[LW-1]}}, s3_y_r}
                  + {{(PW-(QW-HS)){s3_lcb_r[QW-1]}}, s3_lcb_r[QW-1:HS]}
                  + {{(PW-(QW-HS)){s3_lcr_r[QW-1]}}, s3_lcr_r[QW-1:HS]};
  assign cb_mix = {s3_bb_r[QW-1], s3_bb_r} + {s3_br_r[QW-1], s3_br_r};
  assign cr_mix = {s3_rb_r[QW-1], s3_rb_r} + {s3_rr_r[QW-1], s3_rr_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_y_r    <= y2yc_pkg::expand_luma(src_y);
      s1_cb0_r  <= y2yc_pkg::expand_chroma(src_cb);
      s1_cr0_r  <= y2yc_pkg::expand_chroma(src_cr);
      s1_cb1_r  <= y2yc_pkg::expand_chroma(cap_cb_r);
      s1_cr1_r  <= y2yc_pkg::expand_chroma(cap_cr_r);
      s1_odd_r  <= cmd.odd;
      s1_le_r   <= cmd.le;
      s1_last_r <= cmd.last;

      s2_y_r    <= s1_y_r;
      s2_cb_r   <= s1_odd_r ? y2yc_pkg::avg_chroma(s1_cb0_r, s1_cb1_r) : s1_cb0_r;
      s2_cr_r   <= s1_odd_r ? y2yc_pkg::avg_chroma(s1_cr0_r, s1_cr1_r) : s1_cr0_r;
      s2_le_r   <= s1_le_r;
      s2_last_r <= s1_last_r;

      s3_y_r    <= s2_y_r;
      s3_lcb_r  <= s2_cb_r * k_lcb_r;
      s3_lcr_r  <= s2_cr_r * k_lcr_r;
      s3_bb_r   <= s2_cb_r * k_bb_r;
      s3_br_r   <= s2_cr_r * k_br_r;
      s3_rb_r   <= s2_cb_r * k_rb_r;
      s3_rr_r   <= s2_cr_r * k_rr_r;
      s3_le_r   <= s2_le_r;
      s3_last_r <= s2_last_r;

      // shifted mix is always within 16 bits
      pix_luma_r <= luma_sum;
      pix_cb_r   <= cb_mix[QW:MS];
      pix_cr_r   <= cr_mix[QW:MS];
      pix_le_r   <= s3_le_r;
      pix_last_r <= s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pix_luma       = pix_luma_r;
  assign out_pix_cb         = pix_cb_r;
  assign out_pix_cr         = pix_cr_r;
  assign out_pixel_line_end = pix_le_r;
  assign out_run_last       = pix_last_r;

  a_issue_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> adv)
    else $error("pixel issued into a stalled pipeline");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(v3_r) && $stable(pix_last_r)))
    else $error("pipeline moved during stall");

endmodule

// File: hdl/yuy2_to_yc48_upsample_convert.sv
// Each issued pixel passes the expand, upsample, product and sum registers;
// throughput is one pixel per cycle from this four-stage convert pipeline
// while the output does not stall, and a line-end beat flushes the held pair.
// Output stalls freeze the whole pipeline and a busy issue controller.
// Reset (synchronous, rst_n low) empties the pipeline, drops the held pair
// and loads the default matrix coefficients.
module yuy2_to_yc48_upsample_convert (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_luma_even,
  input  logic [7:0]         in_chroma_b,
  input  logic [7:0]         in_luma_odd,
  input  logic [7:0]         in_chroma_r,
  input  logic               in_line_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pix_luma,
  output logic signed [15:0] out_pix_cb,
  output logic signed [15:0] out_pix_cr,
  output logic               out_pixel_line_end,
  output logic               out_run_last
);

  y2yc_pkg::ctl_cmd_t cmd;
  y2yc_pkg::dp_stat_t stat;

  y2yc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_line_end (in_line_end),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  y2yc_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_luma_even       (in_luma_even),
    .in_chroma_b        (in_chroma_b),
    .in_luma_odd        (in_luma_odd),
    .in_chroma_r        (in_chroma_r),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pix_luma       (out_pix_luma),
    .out_pix_cb         (out_pix_cb),
    .out_pix_cr         (out_pix_cr),
    .out_pixel_line_end (out_pixel_line_end),
    .out_run_last       (out_run_last)
  );

endmodule
